// ----- rtl/nmea_sentence_checker_assert.svh -----
// Assertion macros used by the sentence checker top level.
`ifndef NMEA_SENTENCE_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define NSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define NSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nsc_pkg.sv -----
// Types, character constants and helper functions for the sentence checker.
package nsc_pkg;

  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharDollar = 8'h24;

  // Head matcher progress codes beyond the six matched-byte counts.
  localparam logic [3:0] HeadFull   = 4'd6;
  localparam logic [3:0] HeadClosed = 4'd7;
  localparam logic [3:0] HeadFail   = 4'd15;

  localparam logic [7:0] FieldMax = 8'hFF;
  localparam logic [1:0] LenMax   = 2'd3;

  typedef struct packed {
    logic       checksum_ok;
    logic [7:0] checksum_value;
    logic [7:0] field_total;
    logic       is_rmc;
  } result_t;

  // Character of the sentence head "$GPRMC" at a given position.
  function automatic logic [7:0] rmc_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h24;  // '$'
      3'd1:    ch = 8'h47;  // 'G'
      3'd2:    ch = 8'h50;  // 'P'
      3'd3:    ch = 8'h52;  // 'R'
      3'd4:    ch = 8'h4D;  // 'M'
      3'd5:    ch = 8'h43;  // 'C'
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Uppercase ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

// ----- rtl/nmea_sentence_checker.sv -----
// Top level of the NMEA 0183 sentence checker: input register, scan, result register.
//
//   Channel   Direction  tdata                         tlast            tuser
//   s_axis    in         char_byte[7:0]                end_of_sentence  -
//   m_axis    out        ok, value, total, is_rmc      -                -
//
// Every byte sits in the input register, where the scan logic
// updates the running checksum, field tracking and head match in one pass.
// A new byte can be accepted every cycle unless a final byte is waiting; only
// the final byte of a sentence produces a request on m_axis, once it leaves the input register.
// The final byte waits in the input register while the result register is
// still held by an unaccepted result; other bytes never wait on m_axis.
// Reset clears the scan state, so the first byte afterwards starts a sentence.
`include "nmea_sentence_checker_assert.svh"

module nmea_sentence_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // end_of_sentence
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [0] checksum_ok, [8:1] checksum_value,
                                      // [16:9] field_total, [17] is_rmc, rest zero
);

  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             out_vld_q, out_vld_d;
  nsc_pkg::result_t out_res_q;
  nsc_pkg::result_t scan_res;
  logic             out_free;
  logic             advance;
  logic             take_in;

  // The result register is free when empty or when its request is taken now.
  assign out_free = !out_vld_q || m_axis_tready;

  // A byte in the input register moves on unless it is a final byte that
  // would need a result register which is still occupied.
  assign advance = in_vld_q && (!in_last_q || out_free);

  assign s_axis_tready = !in_vld_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = take_in ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  end

  always_comb begin
    if (advance && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_res_q <= scan_res;
    end
  end

  nsc_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .char_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (scan_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_res_q.is_rmc, out_res_q.field_total,
                          out_res_q.checksum_value, out_res_q.checksum_ok};

  // A byte that is not the end of a sentence never creates a result request.
  `NSC_ASSERT_NEXT(a_mid_no_result, advance && !in_last_q && (!out_vld_q || m_axis_tready), !m_axis_tvalid, "result request from a byte inside a sentence")

  // Every final byte that leaves the input register produces a request.
  `NSC_ASSERT_NEXT(a_last_result, advance && in_last_q, m_axis_tvalid, "final byte produced no result request")

  // A blocked byte stays put in the input register.
  `NSC_ASSERT_NEXT(a_in_hold, in_vld_q && !advance, in_vld_q && $stable(in_byte_q) && $stable(in_last_q), "blocked byte lost from input register")

  // A valid sentence always has at least two fields.
  `NSC_ASSERT_NOW(a_ok_fields, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[16:9] >= 8'd2, "checksum_ok with fewer than two fields")

endmodule

// ----- rtl/nsc_scan.sv -----
// Per-sentence scan state: checksum, field tracking and head match.
module nsc_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output nsc_pkg::result_t    result_o
);

  logic [7:0]  xor_q, xor_d, xor_n;
  logic        star_q, star_d, star_n;
  logic [1:0]  cur_len_q, cur_len_d, cur_len_n;
  logic [15:0] cur_chr_q, cur_chr_d, cur_chr_n;
  logic [1:0]  prev_len_q, prev_len_d, prev_len_n;
  logic [15:0] prev_chr_q, prev_chr_d, prev_chr_n;
  logic [7:0]  fields_q, fields_d, fields_n;
  logic        lsep_q, lsep_d, lsep_n;
  logic [3:0]  head_q, head_d, head_n;

  logic        is_sep;
  logic [8:0]  total_wide;
  logic [1:0]  lf_len;
  logic [15:0] lf_chr;
  logic [15:0] want;

  assign is_sep = (char_i == nsc_pkg::CharComma) || (char_i == nsc_pkg::CharStar);

  always_comb begin
    xor_n      = xor_q;
    star_n     = star_q;
    cur_len_n  = cur_len_q;
    cur_chr_n  = cur_chr_q;
    prev_len_n = prev_len_q;
    prev_chr_n = prev_chr_q;
    fields_n   = fields_q;
    lsep_n     = lsep_q;
    head_n     = head_q;

    if (char_i == nsc_pkg::CharStar) begin
      star_n = 1'b1;
    end else if (!star_q && (char_i != nsc_pkg::CharDollar)) begin
      xor_n = xor_q ^ char_i;
    end

    if (fields_q == 8'd0) begin
      if (is_sep) begin
        head_n = (head_q == nsc_pkg::HeadFull) ? nsc_pkg::HeadClosed : nsc_pkg::HeadFail;
      end else if ((head_q < nsc_pkg::HeadFull) &&
                   (char_i == nsc_pkg::rmc_char(head_q[2:0]))) begin
        head_n = head_q + 4'd1;
      end else begin
        head_n = nsc_pkg::HeadFail;
      end
    end

    if (is_sep) begin
      prev_len_n = cur_len_q;
      prev_chr_n = cur_chr_q;
      cur_len_n  = 2'd0;
      cur_chr_n  = 16'd0;
      if (fields_q != nsc_pkg::FieldMax) begin
        fields_n = fields_q + 8'd1;
      end
      lsep_n = 1'b1;
    end else begin
      cur_chr_n = {cur_chr_q[7:0], char_i};
      if (cur_len_q != nsc_pkg::LenMax) begin
        cur_len_n = cur_len_q + 2'd1;
      end
      lsep_n = 1'b0;
    end
  end

  // Result from the updated state; only used when the final byte steps.
  always_comb begin
    total_wide = {1'b0, fields_n} + {8'd0, !lsep_n};
    lf_len     = lsep_n ? prev_len_n : cur_len_n;
    lf_chr     = lsep_n ? prev_chr_n : cur_chr_n;
    want       = {nsc_pkg::hex_char(xor_n[7:4]), nsc_pkg::hex_char(xor_n[3:0])};

    result_o.field_total    = total_wide[8] ? nsc_pkg::FieldMax : total_wide[7:0];
    result_o.checksum_ok    = (total_wide >= 9'd2) && (lf_len == 2'd2) && (lf_chr == want);
    result_o.checksum_value = xor_n;
    result_o.is_rmc         = (head_n == nsc_pkg::HeadClosed) ||
                              (head_n == nsc_pkg::HeadFull);
  end

  // A final byte returns every register to its reset value.
  always_comb begin
    if (last_i) begin
      xor_d      = 8'd0;
      star_d     = 1'b0;
      cur_len_d  = 2'd0;
      cur_chr_d  = 16'd0;
      prev_len_d = 2'd0;
      prev_chr_d = 16'd0;
      fields_d   = 8'd0;
      lsep_d     = 1'b0;
      head_d     = 4'd0;
    end else begin
      xor_d      = xor_n;
      star_d     = star_n;
      cur_len_d  = cur_len_n;
      cur_chr_d  = cur_chr_n;
      prev_len_d = prev_len_n;
      prev_chr_d = prev_chr_n;
      fields_d   = fields_n;
      lsep_d     = lsep_n;
      head_d     = head_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q      <= 8'd0;
      star_q     <= 1'b0;
      cur_len_q  <= 2'd0;
      cur_chr_q  <= 16'd0;
      prev_len_q <= 2'd0;
      prev_chr_q <= 16'd0;
      fields_q   <= 8'd0;
      lsep_q     <= 1'b0;
      head_q     <= 4'd0;
    end else if (step_i) begin
      xor_q      <= xor_d;
      star_q     <= star_d;
      cur_len_q  <= cur_len_d;
      cur_chr_q  <= cur_chr_d;
      prev_len_q <= prev_len_d;
      prev_chr_q <= prev_chr_d;
      fields_q   <= fields_d;
      lsep_q     <= lsep_d;
      head_q     <= head_d;
    end
  end

endmodule
